FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or plain property on every rising clock edge outside reset.
`define BM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define BM_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/bmscan_pkg.sv
`timescale 1ns / 1ps

package bmscan_pkg;

  localparam int WORD_COUNT = 1024;
  localparam int WORD_W     = 32;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CAPACITY   = WORD_COUNT * WORD_W;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int HIT_W      = ADDR_W + 5;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_RESET = 2'd1;
  localparam logic [1:0] KIND_FIND  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic        changed;
    logic        found;
    logic [14:0] found_index;
    logic [15:0] total_set;
    logic        out_of_range;
  } res_t;

  // Position of the lowest set bit; 31 when the word is empty.
  function automatic logic [4:0] lowest_bit(input logic [31:0] w);
    logic [4:0] p;
    p = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (w[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: rtl/bmscan_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module bmscan_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bitmap_set_reset_count_scan_top.sv
`timescale 1ns / 1ps

// Channel   | Direction | Signals                                        | Beat
// ----------+-----------+------------------------------------------------+---------------------
// request   | in        | in_valid, in_ready, in_kind, in_index          | one request
// result    | out       | out_valid, out_ready, out_changed, out_found,  | one result per
//           |           | out_found_index, out_total_set,                | request
//           |           | out_out_of_range                               |
//
// For set, reset and out-of-range requests the word read is issued at accept; the S_RMW state
// then writes the word back, or the S_RESP state hands on the flagged result. Find-next reads
// words in S_SCAN up to the one that holds the hit or up to the last word. Clear-all writes
// zero to every word in S_CLEAR, one RAM write per word; after reset the same sweep runs and
// no request is taken until it ends. A result held in the output register lets the next
// request run; its result then waits, stalling the input.

`include "assert_macros.svh"

module bitmap_set_reset_count_scan_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_changed,
  output logic        out_found,
  output logic [14:0] out_found_index,
  output logic [15:0] out_total_set,
  output logic        out_out_of_range
);

  localparam int AW = bmscan_pkg::ADDR_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam logic [AW-1:0] LAST_ADDR = AW'(bmscan_pkg::WORD_COUNT - 1);

  logic [2:0]                       state_r, state_nxt;
  logic [AW-1:0]                    word_r, word_nxt;
  logic [4:0]                       pos_r, pos_nxt;
  logic [1:0]                       kind_r, kind_nxt;
  logic                             first_r, first_nxt;
  logic [AW-1:0]                    clr_addr_r, clr_addr_nxt;
  logic                             clr_req_r, clr_req_nxt;
  logic [bmscan_pkg::COUNT_W-1:0]   count_r, count_nxt;
  bmscan_pkg::res_t                 res_r, res_nxt;
  bmscan_pkg::res_t                 out_r, out_nxt;
  logic                             out_valid_r, out_valid_nxt;

  logic                             in_fire;
  logic                             in_oor;
  logic [AW-1:0]                    in_word;
  logic                             slot_free;
  logic                             fin_valid;
  bmscan_pkg::res_t                 fin;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [31:0]                      mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic [31:0]                      mem_rdata;

  logic [31:0]                      scan_word;
  logic [bmscan_pkg::HIT_W-1:0]     hit;
  logic                             cur_bit;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_oor    = (in_index >= 32'(bmscan_pkg::CAPACITY));
  assign in_word   = in_index[AW+4:5];
  assign slot_free = !out_valid_r || out_ready;

  // The first word of a search is masked below the start position.
  assign scan_word = first_r ? (mem_rdata & (32'hFFFF_FFFF << pos_r)) : mem_rdata;
  assign hit       = {word_r, bmscan_pkg::lowest_bit(scan_word)};
  assign cur_bit   = mem_rdata[pos_r];

  // Read address: the request's word at accept, the following word during a search.
  always_comb begin
    mem_raddr = in_word;
    if (state_r == S_SCAN) begin
      mem_raddr = word_r + AW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    pos_nxt       = pos_r;
    kind_nxt      = kind_r;
    first_nxt     = first_r;
    clr_addr_nxt  = clr_addr_r;
    clr_req_nxt   = clr_req_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    fin_valid     = 1'b0;
    fin           = '0;
    mem_we        = 1'b0;
    mem_waddr     = word_r;
    mem_wdata     = mem_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_nxt  = in_kind;
          word_nxt  = in_word;
          pos_nxt   = in_index[4:0];
          first_nxt = 1'b1;
          if (in_kind == bmscan_pkg::KIND_CLEAR) begin
            count_nxt    = '0;
            clr_addr_nxt = '0;
            clr_req_nxt  = 1'b1;
            state_nxt    = S_CLEAR;
          end else if (in_oor) begin
            res_nxt              = '0;
            res_nxt.total_set    = 16'(count_r);
            res_nxt.out_of_range = 1'b1;
            state_nxt            = S_RESP;
          end else if (in_kind == bmscan_pkg::KIND_FIND) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RMW;
          end
        end
      end

      S_RMW: begin
        fin_valid = 1'b1;
        if (kind_r == bmscan_pkg::KIND_SET) begin
          if (!cur_bit) begin
            mem_we      = 1'b1;
            mem_wdata   = mem_rdata | (32'd1 << pos_r);
            count_nxt   = count_r + bmscan_pkg::COUNT_W'(1);
            fin.changed = 1'b1;
          end
        end else begin
          if (cur_bit) begin
            mem_we      = 1'b1;
            mem_wdata   = mem_rdata & ~(32'd1 << pos_r);
            count_nxt   = count_r - bmscan_pkg::COUNT_W'(1);
            fin.changed = 1'b1;
          end
        end
        fin.total_set = 16'(count_nxt);
      end

      S_SCAN: begin
        first_nxt = 1'b0;
        if (scan_word != 32'd0) begin
          fin_valid       = 1'b1;
          fin.found       = 1'b1;
          fin.found_index = 15'(hit);
          fin.total_set   = 16'(count_r);
        end else if (word_r == LAST_ADDR) begin
          fin_valid     = 1'b1;
          fin.total_set = 16'(count_r);
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end

      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == LAST_ADDR) begin
          if (clr_req_r) begin
            fin_valid = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end

      S_RESP: begin
        fin_valid = 1'b1;
        fin       = res_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A finished result goes to the output register, or waits in S_RESP.
    if (fin_valid) begin
      res_nxt = fin;
      if (slot_free) begin
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_RESP;
      end
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (fin_valid && slot_free) begin
      out_nxt       = fin;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_req_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_req_r   <= clr_req_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pos_r  <= pos_nxt;
    kind_r <= kind_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  bmscan_ram #(
    .DEPTH  (bmscan_pkg::WORD_COUNT),
    .WIDTH  (32),
    .ADDR_W (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_changed      = out_r.changed;
  assign out_found        = out_r.found;
  assign out_found_index  = out_r.found_index;
  assign out_total_set    = out_r.total_set;
  assign out_out_of_range = out_r.out_of_range;

  `BM_ASSERT(a_count_cap, clk, rst_n, count_r <= bmscan_pkg::COUNT_W'(bmscan_pkg::CAPACITY), "set count exceeds capacity")
  `BM_ASSERT(a_rmw_follows, clk, rst_n, in_fire && !in_oor && (in_kind == bmscan_pkg::KIND_SET || in_kind == bmscan_pkg::KIND_RESET) |=> state_r == S_RMW, "set or reset did not enter read-modify-write")
  `BM_ASSERT(a_write_states, clk, rst_n, mem_we |-> (state_r == S_RMW || state_r == S_CLEAR), "RAM written outside update or clear")
  `BM_NEVER(a_out_from_idle, clk, rst_n, $rose(out_valid_r) && $past(state_r) == S_IDLE, "result raised without a finishing state")

endmodule
